/* rtl/lsh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_pkg: shared definitions for the Laplacian sharpen stream
// Field widths, configuration codes and reset values, control flag and
// result types, and the cross-kernel arithmetic.
// ----------------------------------------------------------------------------
package lsh_pkg;

    // Default line buffer depth in samples
    localparam int MAX_LINE_SAMPLES_DEF = 16384;

    // Field widths
    localparam int SAMPLE_W   = 8;
    localparam int ROW_W      = 12;
    localparam int SIDX_W     = 14;
    localparam int DIM_W      = 13;
    localparam int CHAN_W     = 3;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Configuration reset values and legal ranges
    localparam logic [DIM_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = 13'd480;
    localparam logic [CHAN_W-1:0] CHAN_RESET   = 3'd3;
    localparam logic [DIM_W-1:0]  DIM_MIN      = 13'd3;
    localparam logic [DIM_W-1:0]  DIM_MAX      = 13'd4096;
    localparam logic [CHAN_W-1:0] CHAN_MIN     = 3'd1;
    localparam logic [CHAN_W-1:0] CHAN_MAX     = 3'd4;

    // History of the row above, one entry per possible channel
    localparam int HIST_DEPTH = 4;
    localparam int HIST_SEL_W = 2;

    // Result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } cfg_index_t;

    // Per-item control flags
    typedef struct packed {
        logic emit;      // row above exists, one result at least
        logic interior;  // row above sample gets the kernel
        logic last_row;  // incoming row is the last one, copy it out too
        logic eoi;       // final sample of the image
    } item_flags_t;

    // One result item
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [ROW_W-1:0]    row;
        logic [SIDX_W-1:0]   sidx;
        logic                eoi;
    } result_t;

    // 5*c - left - right - up - down, clamped to a byte
    function automatic logic [SAMPLE_W-1:0] sharpen(
        input logic [SAMPLE_W-1:0] c,
        input logic [SAMPLE_W-1:0] l,
        input logic [SAMPLE_W-1:0] r,
        input logic [SAMPLE_W-1:0] u,
        input logic [SAMPLE_W-1:0] d
    );
        logic [11:0] acc;
        logic [SAMPLE_W-1:0] res;
        acc = 12'({c, 2'b00}) + 12'(c) - 12'(l) - 12'(r) - 12'(u) - 12'(d);
        if (acc[11]) begin
            res = '0;
        end
        else if (acc[10:8] != 3'd0) begin
            res = '1;
        end
        else begin
            res = acc[7:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/lsh_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_seq: configuration and raster position sequencer
// Holds the configuration registers and the row and sample counters, and
// produces the line buffer addresses and control flags for each transfer.
// ----------------------------------------------------------------------------
module lsh_seq #(
    parameter int MAX_LINE_SAMPLES = lsh_pkg::MAX_LINE_SAMPLES_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [lsh_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  logic                                     accept,
    output logic [$clog2(MAX_LINE_SAMPLES)-1:0]      pos,
    output logic [$clog2(MAX_LINE_SAMPLES)-1:0]      ahead_pos,
    output logic [lsh_pkg::ROW_W-1:0]                row,
    output lsh_pkg::item_flags_t                     flags,
    output logic [lsh_pkg::HIST_SEL_W-1:0]           hist_sel
);
    import lsh_pkg::*;

    localparam int AW = $clog2(MAX_LINE_SAMPLES);
    localparam int LW = $clog2(MAX_LINE_SAMPLES + 1);
    localparam int SW = LW + 1;

    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic [AW-1:0]     sample_cnt_reg, sample_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;

    logic [DIM_W-1:0]  w_sat, h_sat;
    logic [CHAN_W-1:0] ch_sat;
    logic [15:0]       line_prod;
    logic [16:0]       line_wide;
    logic [LW-1:0]     line_len;
    logic [AW-1:0]     cur_pos;
    logic [ROW_W-1:0]  cur_row;
    logic [SW-1:0]     ahead_sum, pos_inc;
    logic [DIM_W-1:0]  row_inc;
    logic              line_wrap, row_wrap;

    // Configuration writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        chan_next   = chan_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   width_next  = cfg_data;
                CFG_IMAGE_HEIGHT:  height_next = cfg_data;
                CFG_CHANNEL_COUNT: chan_next   = cfg_data[CHAN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Saturate configuration into its legal range and form the row length
    always_comb
    begin
        w_sat  = (width_reg < DIM_MIN) ? DIM_MIN :
                 (width_reg > DIM_MAX) ? DIM_MAX : width_reg;
        h_sat  = (height_reg < DIM_MIN) ? DIM_MIN :
                 (height_reg > DIM_MAX) ? DIM_MAX : height_reg;
        ch_sat = (chan_reg < CHAN_MIN) ? CHAN_MIN :
                 (chan_reg > CHAN_MAX) ? CHAN_MAX : chan_reg;
        line_prod = 16'(w_sat) * 16'(ch_sat);
        line_wide = (17'(line_prod) > 17'(MAX_LINE_SAMPLES)) ?
                    17'(MAX_LINE_SAMPLES) : 17'(line_prod);
        line_len  = LW'(line_wide);
    end

    // Restart counters beyond the current geometry, derive flags
    always_comb
    begin
        cur_pos   = (LW'(sample_cnt_reg) >= line_len) ? '0 : sample_cnt_reg;
        cur_row   = ({1'b0, row_cnt_reg} >= h_sat) ? '0 : row_cnt_reg;
        ahead_sum = SW'(cur_pos) + SW'(ch_sat);

        flags.emit     = (cur_row != '0);
        flags.interior = (cur_row >= ROW_W'(2)) && (SW'(cur_pos) >= SW'(ch_sat))
                         && (ahead_sum < SW'(line_len));
        flags.last_row = ({1'b0, cur_row} == (h_sat - DIM_W'(1)));
        flags.eoi      = flags.last_row && (SW'(cur_pos) == (SW'(line_len) - SW'(1)));

        pos       = cur_pos;
        ahead_pos = AW'(ahead_sum);
        row       = cur_row;
        hist_sel  = HIST_SEL_W'(ch_sat - CHAN_W'(1));
    end

    // Advance the raster position on each transfer
    always_comb
    begin
        pos_inc   = SW'(cur_pos) + SW'(1);
        row_inc   = {1'b0, cur_row} + DIM_W'(1);
        line_wrap = (pos_inc >= SW'(line_len));
        row_wrap  = (row_inc >= h_sat);
        sample_cnt_next = sample_cnt_reg;
        row_cnt_next    = row_cnt_reg;
        if (accept)
        begin
            if (line_wrap)
            begin
                sample_cnt_next = '0;
                row_cnt_next    = row_wrap ? '0 : ROW_W'(row_inc);
            end
            else
            begin
                sample_cnt_next = AW'(pos_inc);
                row_cnt_next    = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            chan_reg       <= CHAN_RESET;
            sample_cnt_reg <= '0;
            row_cnt_reg    <= '0;
        end
        else
        begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            chan_reg       <= chan_next;
            sample_cnt_reg <= sample_cnt_next;
            row_cnt_reg    <= row_cnt_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/lsh_line_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_line_mem: line buffer memories and kernel taps
// Two synchronous line memories hold the last two rows. A transfer reads the
// row above at the current and right positions and the row two up at the
// current position, and overwrites the recent row. In the following cycle the old
// recent value moves to the older row, and a short history supplies the left
// neighbor.
// ----------------------------------------------------------------------------
module lsh_line_mem #(
    parameter int MAX_LINE_SAMPLES = lsh_pkg::MAX_LINE_SAMPLES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic [$clog2(MAX_LINE_SAMPLES)-1:0]   pos,
    input  logic [$clog2(MAX_LINE_SAMPLES)-1:0]   ahead_pos,
    input  logic [lsh_pkg::ROW_W-1:0]             row,
    input  lsh_pkg::item_flags_t                  flags,
    input  logic [lsh_pkg::HIST_SEL_W-1:0]        hist_sel,
    input  logic [lsh_pkg::SAMPLE_W-1:0]          sample,
    output logic                                  tap_valid,
    output lsh_pkg::item_flags_t                  tap_flags,
    output logic [lsh_pkg::ROW_W-1:0]             tap_row,
    output logic [lsh_pkg::SIDX_W-1:0]            tap_sidx,
    output logic [lsh_pkg::SAMPLE_W-1:0]          tap_cur,
    output logic [lsh_pkg::SAMPLE_W-1:0]          tap_left,
    output logic [lsh_pkg::SAMPLE_W-1:0]          tap_right,
    output logic [lsh_pkg::SAMPLE_W-1:0]          tap_up,
    output logic [lsh_pkg::SAMPLE_W-1:0]          tap_down
);
    import lsh_pkg::*;

    localparam int AW = $clog2(MAX_LINE_SAMPLES);

    logic [SAMPLE_W-1:0] recent_mem [MAX_LINE_SAMPLES];
    logic [SAMPLE_W-1:0] older_mem  [MAX_LINE_SAMPLES];

    logic [SAMPLE_W-1:0] cur_rd_reg, right_rd_reg, up_rd_reg;
    logic [SAMPLE_W-1:0] hist_reg [HIST_DEPTH];

    logic                stage_valid_reg, stage_valid_next;
    item_flags_t         stage_flags_reg;
    logic [AW-1:0]       stage_pos_reg;
    logic [ROW_W-1:0]    stage_row_reg;
    logic [SAMPLE_W-1:0] stage_down_reg;

    // Read the taps and overwrite the recent row on a transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            recent_mem[pos] <= sample;
            cur_rd_reg      <= recent_mem[pos];
            right_rd_reg    <= recent_mem[ahead_pos];
            up_rd_reg       <= older_mem[pos];
        end
    end

    // Retire the row above into the older row in the cycle after the read
    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
        begin
            older_mem[stage_pos_reg] <= cur_rd_reg;
        end
    end

    // Shift the row above history, newest in entry zero
    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
        begin
            hist_reg[0] <= cur_rd_reg;
            for (int i = 1; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // Stage control
    assign stage_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Stage payload, lines up with the read data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_flags_reg <= flags;
            stage_pos_reg   <= pos;
            stage_row_reg   <= row;
            stage_down_reg  <= sample;
        end
    end

    // Drive the taps
    assign tap_valid = stage_valid_reg;
    assign tap_flags = stage_flags_reg;
    assign tap_row   = stage_row_reg;
    assign tap_sidx  = SIDX_W'(stage_pos_reg);
    assign tap_cur   = cur_rd_reg;
    assign tap_left  = hist_reg[hist_sel];
    assign tap_right = right_rd_reg;
    assign tap_up    = up_rd_reg;
    assign tap_down  = stage_down_reg;

endmodule
`default_nettype wire

/* rtl/lsh_result_q.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_result_q: kernel result formation and output queue
// Forms the row above result and, on the last row, the copy of the incoming
// sample, queues them and presents the head on the output channel. Holds off
// input transfers while the queue could not take two more results.
// ----------------------------------------------------------------------------
module lsh_result_q (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tap_valid,
    input  lsh_pkg::item_flags_t          tap_flags,
    input  logic [lsh_pkg::ROW_W-1:0]     tap_row,
    input  logic [lsh_pkg::SIDX_W-1:0]    tap_sidx,
    input  logic [lsh_pkg::SAMPLE_W-1:0]  tap_cur,
    input  logic [lsh_pkg::SAMPLE_W-1:0]  tap_left,
    input  logic [lsh_pkg::SAMPLE_W-1:0]  tap_right,
    input  logic [lsh_pkg::SAMPLE_W-1:0]  tap_up,
    input  logic [lsh_pkg::SAMPLE_W-1:0]  tap_down,
    input  logic                          out_stall,
    output logic                          in_stall,
    output logic                          out_valid,
    output logic [lsh_pkg::SAMPLE_W-1:0]  value,
    output logic [lsh_pkg::ROW_W-1:0]     row_index,
    output logic [lsh_pkg::SIDX_W-1:0]    sample_index,
    output logic                          end_of_image
);
    import lsh_pkg::*;

    result_t               q_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0]   count_reg, count_next;

    result_t               above_res, copy_res, head;
    logic                  push_above, push_copy, pop;
    logic [RQ_CNT_W-1:0]   push_n;

    // Form the two possible results
    always_comb
    begin
        above_res.value = tap_flags.interior ?
                          sharpen(tap_cur, tap_left, tap_right, tap_up, tap_down) :
                          tap_cur;
        above_res.row   = tap_row - ROW_W'(1);
        above_res.sidx  = tap_sidx;
        above_res.eoi   = 1'b0;

        copy_res.value  = tap_down;
        copy_res.row    = tap_row;
        copy_res.sidx   = tap_sidx;
        copy_res.eoi    = tap_flags.eoi;

        push_above = tap_valid && tap_flags.emit;
        push_copy  = push_above && tap_flags.last_row;
        push_n     = RQ_CNT_W'(push_above) + RQ_CNT_W'(push_copy);
    end

    // Hold off input while the queue and the item in flight leave under two free
    assign in_stall = ((count_reg + push_n) > RQ_CNT_W'(RQ_DEPTH - 2));

    // Output head
    assign head         = q_reg[rd_ptr_reg];
    assign out_valid    = (count_reg != '0);
    assign value        = head.value;
    assign row_index    = head.row;
    assign sample_index = head.sidx;
    assign end_of_image = head.eoi;
    assign pop          = out_valid && !out_stall;

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(pop);
        count_next  = count_reg + push_n - RQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, the copy lands right after the row above result
    always_ff @(posedge clk)
    begin
        if (push_above)
        begin
            q_reg[wr_ptr_reg] <= above_res;
        end
        if (push_copy)
        begin
            q_reg[wr_ptr_reg + RQ_PTR_W'(1)] <= copy_res;
        end
    end

endmodule
`default_nettype wire

/* rtl/laplacian_sharpen_3x3_stream.sv */
`default_nettype none
// Path: each result passes the line memory read registers, then the result queue.
// Throughput: one input sample per cycle while in_stall is low; during the last row
//   each input makes two results, so the single output port holds input back.
// Reset: clears counters and the result queue, loads 640 x 480 x 3 geometry.
//   Line memories are not cleared; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_stream: streaming cross-kernel sharpen
// Raster-order interleaved samples in; each row above is sharpened with
// 5*c minus its four same-channel neighbors, borders copied, last row copied.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_stream #(
    parameter int MAX_LINE_SAMPLES = lsh_pkg::MAX_LINE_SAMPLES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lsh_pkg::SAMPLE_W-1:0]   sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lsh_pkg::SAMPLE_W-1:0]   value,
    output logic [lsh_pkg::ROW_W-1:0]      row_index,
    output logic [lsh_pkg::SIDX_W-1:0]     sample_index,
    output logic                           end_of_image
);
    import lsh_pkg::*;

    localparam int AW = $clog2(MAX_LINE_SAMPLES);

    logic                  accept;
    logic [AW-1:0]         pos, ahead_pos;
    logic [ROW_W-1:0]      row;
    item_flags_t           flags;
    logic [HIST_SEL_W-1:0] hist_sel;

    logic                  tap_valid;
    item_flags_t           tap_flags;
    logic [ROW_W-1:0]      tap_row;
    logic [SIDX_W-1:0]     tap_sidx;
    logic [SAMPLE_W-1:0]   tap_cur, tap_left, tap_right, tap_up, tap_down;

    // Input transfer
    assign accept = in_valid && !in_stall;

    lsh_seq #(
        .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pos       (pos),
        .ahead_pos (ahead_pos),
        .row       (row),
        .flags     (flags),
        .hist_sel  (hist_sel)
    );

    lsh_line_mem #(
        .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES)
    ) u_line_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .pos       (pos),
        .ahead_pos (ahead_pos),
        .row       (row),
        .flags     (flags),
        .hist_sel  (hist_sel),
        .sample    (sample),
        .tap_valid (tap_valid),
        .tap_flags (tap_flags),
        .tap_row   (tap_row),
        .tap_sidx  (tap_sidx),
        .tap_cur   (tap_cur),
        .tap_left  (tap_left),
        .tap_right (tap_right),
        .tap_up    (tap_up),
        .tap_down  (tap_down)
    );

    lsh_result_q u_result_q (
        .clk          (clk),
        .rst_n        (rst_n),
        .tap_valid    (tap_valid),
        .tap_flags    (tap_flags),
        .tap_row      (tap_row),
        .tap_sidx     (tap_sidx),
        .tap_cur      (tap_cur),
        .tap_left     (tap_left),
        .tap_right    (tap_right),
        .tap_up       (tap_up),
        .tap_down     (tap_down),
        .out_stall    (out_stall),
        .in_stall     (in_stall),
        .out_valid    (out_valid),
        .value        (value),
        .row_index    (row_index),
        .sample_index (sample_index),
        .end_of_image (end_of_image)
    );

endmodule
`default_nettype wire

/* rtl/lsh_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_checker: port-level checks for the Laplacian sharpen stream
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module lsh_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [lsh_pkg::SAMPLE_W-1:0]   value,
    input  logic [lsh_pkg::ROW_W-1:0]      row_index,
    input  logic [lsh_pkg::SIDX_W-1:0]     sample_index,
    input  logic                           end_of_image
);
    import lsh_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid &&
        $stable({value, row_index, sample_index, end_of_image}))
        else $error("stalled result changed or dropped");

    // A result that first shows on the output must follow an input transfer
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without a matching input transfer");

    // End of image never lies before row two or before sample index two
    a_eoi_place: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_image |->
        (row_index >= ROW_W'(2)) && (sample_index >= SIDX_W'(2)))
        else $error("end of image flagged at an impossible position");

endmodule

bind laplacian_sharpen_3x3_stream lsh_checker u_lsh_checker (.*);
`default_nettype wire
